>>> hdl/dsds_pkg.sv
package dsds_pkg;

   localparam int NumberWidth  = 32;
   localparam int DigitWidth   = 4;
   localparam int SegWidth     = 7;
   localparam int SelectWidth  = 8;
   localparam int MaxDigits    = 10;

   // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
   localparam logic [NumberWidth-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT = 35;

   localparam logic [SelectWidth-1:0] SELECT_BASE = 8'hFE;

   function automatic logic [SegWidth-1:0] seg_of_digit(input logic [DigitWidth-1:0] digit);
      logic [SegWidth-1:0] seg;
      case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

   // rotate the active-low base left by a position modulo eight
   function automatic logic [SelectWidth-1:0] select_of_pos(input logic [2:0] rot);
      logic [2*SelectWidth-1:0] wide;
      wide = {SELECT_BASE, SELECT_BASE} << rot;
      return wide[2*SelectWidth-1:SelectWidth];
   endfunction

endpackage

>>> hdl/dsds_div10.sv
module dsds_div10 (
   input  logic [dsds_pkg::NumberWidth-1:0] value,
   output logic [dsds_pkg::NumberWidth-1:0] quotient,
   output logic [dsds_pkg::DigitWidth-1:0]  remainder
);
   import dsds_pkg::*;

   logic [2*NumberWidth-1:0] product;
   logic [NumberWidth-1:0]   times_ten;
   logic [NumberWidth-1:0]   diff;

   // reciprocal multiply, then back out the remainder with shift-add
   assign product   = {{NumberWidth{1'b0}}, value} * {{NumberWidth{1'b0}}, RECIP_TEN};
   assign quotient  = NumberWidth'(product[2*NumberWidth-1:RECIP_SHIFT]);
   assign times_ten = (quotient << 3) + (quotient << 1);
   assign diff      = value - times_ten;
   assign remainder = diff[DigitWidth-1:0];

endmodule

>>> hdl/dsds_conv.sv
module dsds_conv #(
   parameter int DIGITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dsds_pkg::NumberWidth-1:0] req_number_in,
   output logic                             busy,
   output logic                             handoff,
   output logic [dsds_pkg::DigitWidth-1:0]  handoff_digits [DIGITS]
);
   import dsds_pkg::*;

   localparam int CountWidth = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(DIGITS - 1);

   logic                   active_ff, active_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [NumberWidth-1:0] value_ff, value_in;
   logic [DigitWidth-1:0]  digits_ff [DIGITS];
   logic [DigitWidth-1:0]  digits_in [DIGITS];

   logic [NumberWidth-1:0] quotient;
   logic [DigitWidth-1:0]  remainder;
   logic                   accept;
   logic                   last_step;

   dsds_div10 u_div10 (
      .value     (value_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign last_step = active_ff && (count_ff == LastCount);
   assign busy      = active_ff && !last_step;
   assign accept    = start && !busy;
   assign handoff   = last_step;

   // shift the new digit in at the top: the LSD ends up in entry 0
   always_comb begin
      for (int k = 0; k < DIGITS - 1; k++) begin
         digits_in[k] = digits_ff[k+1];
      end
      digits_in[DIGITS-1] = remainder;
   end

   assign handoff_digits = digits_in;

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      value_in  = value_ff;
      if (accept) begin
         active_in = 1'b1;
         count_in  = '0;
         value_in  = req_number_in;
      end else if (last_step) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         count_in = count_ff + 1'b1;
         value_in = quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
      value_ff <= value_in;
      if (active_ff) begin
         digits_ff <= digits_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> active_ff && (count_ff == '0))
      else $error("conversion did not start on accepted request");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      last_step && !accept |=> !active_ff)
      else $error("converter still active after last digit");

endmodule

>>> hdl/dsds_scan.sv
module dsds_scan #(
   parameter int DIGITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [dsds_pkg::DigitWidth-1:0]  load_digits [DIGITS],
   output logic                             rsp_strobe,
   output logic [dsds_pkg::SelectWidth-1:0] rsp_digit_select,
   output logic [dsds_pkg::SegWidth-1:0]    rsp_segment_pattern,
   output logic [dsds_pkg::DigitWidth-1:0]  rsp_digit_value,
   output logic                             rsp_last_digit
);
   import dsds_pkg::*;

   localparam int CountWidth = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [CountWidth-1:0] LastPos = CountWidth'(DIGITS - 1);

   logic                  active_ff, active_in;
   logic [CountWidth-1:0] pos_ff, pos_in;
   logic [DigitWidth-1:0] digits_ff [DIGITS];

   logic                  at_last;
   logic                  can_load;
   logic [CountWidth-1:0] digit_index;
   logic [3:0]            pos_wide;
   logic [DigitWidth-1:0] digit;

   assign at_last  = pos_ff == LastPos;
   assign can_load = !active_ff || at_last;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      if (load) begin
         active_in = 1'b1;
         pos_in    = '0;
      end else if (active_ff && at_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
      if (load) begin
         digits_ff <= load_digits;
      end
   end

   // MSD sits in the top entry, so walk down from there
   assign digit_index = LastPos - pos_ff;
   assign digit       = digits_ff[digit_index];
   assign pos_wide    = 4'(pos_ff);

   assign rsp_strobe          = active_ff;
   assign rsp_digit_value     = digit;
   assign rsp_segment_pattern = seg_of_digit(digit);
   assign rsp_digit_select    = select_of_pos(pos_wide[2:0]);
   assign rsp_last_digit      = at_last;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("scan loaded while a run is still in progress");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      active_ff && !at_last |=> active_ff && (pos_ff == $past(pos_ff) + 1'b1))
      else $error("scan run broke off before the last digit");

endmodule

>>> hdl/decimal_seven_segment_digit_scan.sv
// Decimal seven-segment digit scan. Raise start with a number on
// req_number_in; the request is taken at the clock edge where busy is low.
// The block splits the number into DIGIT_COUNT decimal digits (higher digits
// are dropped, leading zeros show as 0) and sends one result per digit, most
// significant first, on consecutive cycles marked by rsp_strobe. Each result
// carries the digit, its common-cathode segment pattern (bit 0 = segment a)
// and the active-low digit select; rsp_last_digit marks the final digit.
// The receiver cannot stall: every result is on the ports for exactly one
// cycle and must be taken then. The divide-by-ten unit peels off one digit
// per cycle, and a new request can be taken while the last digit of the
// previous request is peeled off, so its conversion can overlap the scan-out
// of the previous request's digits.
module decimal_seven_segment_digit_scan #(
   parameter int DIGIT_COUNT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dsds_pkg::NumberWidth-1:0] req_number_in,
   output logic                             rsp_strobe,
   output logic [dsds_pkg::SelectWidth-1:0] rsp_digit_select,
   output logic [dsds_pkg::SegWidth-1:0]    rsp_segment_pattern,
   output logic [dsds_pkg::DigitWidth-1:0]  rsp_digit_value,
   output logic                             rsp_last_digit
);
   import dsds_pkg::*;

   // clamp the digit count to the supported range
   localparam int Digits = (DIGIT_COUNT < 1) ? 1 :
                           ((DIGIT_COUNT > MaxDigits) ? MaxDigits : DIGIT_COUNT);

   logic                  handoff;
   logic [DigitWidth-1:0] handoff_digits [Digits];

   // Convert: take the request and peel off one digit per cycle.
   dsds_conv #(
      .DIGITS (Digits)
   ) u_conv (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_number_in  (req_number_in),
      .busy           (busy),
      .handoff        (handoff),
      .handoff_digits (handoff_digits)
   );

   // Scan: hold the finished digits and emit them MSD first. The scan run
   // always ends on or before the next handoff, so no waiting is needed.
   dsds_scan #(
      .DIGITS (Digits)
   ) u_scan (
      .clock               (clock),
      .reset               (reset),
      .load                (handoff),
      .load_digits         (handoff_digits),
      .rsp_strobe          (rsp_strobe),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_value     (rsp_digit_value),
      .rsp_last_digit      (rsp_last_digit)
   );

endmodule

>>> dv/decimal_seven_segment_digit_scan_test.sv
module decimal_seven_segment_digit_scan_test;

   import dsds_pkg::*;

   localparam int DIGITS          = 8;
   localparam int ITEMS_PER_PHASE = 132;
   localparam int DIRECTED_ROWS   = 16;

   // one scanned-out digit as the block should present it
   typedef struct packed {
      logic [SelectWidth-1:0] select;
      logic [SegWidth-1:0]    segments;
      logic [DigitWidth-1:0]  digit;
      logic                   last;
   } digit_result_type;

   // directed row: the number, and where it is plain to read, its digits
   // typed in as BCD (most significant digit in the top nibble)
   typedef struct packed {
      logic [NumberWidth-1:0] number;
      logic                   has_bcd;
      logic [4*DIGITS-1:0]    bcd;
   } scan_row_type;

   localparam logic [SegWidth-1:0] SEGMENT_CODE [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   localparam int unsigned POWER_OF_TEN [10] = '{
      1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000, 1000000000
   };

   scan_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'd0,          1'b1, 32'h0000_0000},
      '{32'd1,          1'b0, 32'h0},
      '{32'd9,          1'b0, 32'h0},
      '{32'd10,         1'b0, 32'h0},
      '{32'd99999999,   1'b1, 32'h9999_9999},
      // one past eight digits: everything above the eighth digit drops
      '{32'd100000000,  1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF,  1'b1, 32'h9496_7295},
      '{32'd12345678,   1'b1, 32'h1234_5678},
      '{32'd87654321,   1'b0, 32'h0},
      '{32'd1234567890, 1'b1, 32'h3456_7890},
      '{32'h8000_0000,  1'b0, 32'h0},
      '{32'h5555_5555,  1'b0, 32'h0},
      '{32'hAAAA_AAAA,  1'b0, 32'h0},
      '{32'd10000000,   1'b0, 32'h0},
      '{32'd9999999,    1'b1, 32'h0999_9999},
      '{32'd65535,      1'b0, 32'h0}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [NumberWidth-1:0] req_number_in;
   logic                   rsp_strobe;
   logic [SelectWidth-1:0] rsp_digit_select;
   logic [SegWidth-1:0]    rsp_segment_pattern;
   logic [DigitWidth-1:0]  rsp_digit_value;
   logic                   rsp_last_digit;

   // digits still owed by the block, oldest first
   digit_result_type pending_digits[$];
   digit_result_type scan_head;

   int mismatch_count;
   int request_count;
   int digit_count;
   int idle_percent;

   decimal_seven_segment_digit_scan #(
      .DIGIT_COUNT(DIGITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_number_in       (req_number_in),
      .rsp_strobe          (rsp_strobe),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_value     (rsp_digit_value),
      .rsp_last_digit      (rsp_last_digit)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("error at %0t: %s got 'h%0h, expected 'h%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // peel off the low DIGITS decimal digits, higher digits fall away
   function automatic logic [4*DIGITS-1:0] bcd_of(input logic [NumberWidth-1:0] number);
      logic [4*DIGITS-1:0] bcd;
      int unsigned         rest;
      bcd  = '0;
      rest = number;
      for (int i = 0; i < DIGITS; i++) begin
         bcd[4*i +: 4] = 4'(rest % 10);
         rest          = rest / 10;
      end
      return bcd;
   endfunction

   // queue one result per digit, most significant first; the select is
   // the active-low one-hot at position modulo eight
   task automatic queue_digit_run(input logic [4*DIGITS-1:0] bcd);
      digit_result_type r;
      for (int pos = 0; pos < DIGITS; pos++) begin
         r.digit    = bcd[4*(DIGITS-1-pos) +: 4];
         r.segments = SEGMENT_CODE[r.digit];
         r.select   = ~(8'h01 << (pos % 8));
         r.last     = (pos == DIGITS - 1);
         pending_digits.push_back(r);
      end
   endtask

   // raise start with the number, hold it until the block takes it, then
   // drop start for a random gap unless the next request follows at once
   task automatic send_request(input logic [NumberWidth-1:0] number,
                               input logic has_bcd, input logic [4*DIGITS-1:0] bcd);
      start         <= 1'b1;
      req_number_in <= number;
      do
         @(posedge clock);
      while (busy);
      queue_digit_run(has_bcd ? bcd : bcd_of(number));
      request_count++;
      if ($urandom_range(99) < idle_percent) begin
         start         <= 1'b0;
         req_number_in <= $urandom;
         do
            @(posedge clock);
         while ($urandom_range(99) < idle_percent);
      end
   endtask

   // spread numbers over the full range, the eight-digit range, small values,
   // the edges around powers of ten and the very top of the range
   function automatic logic [NumberWidth-1:0] pick_number();
      logic [NumberWidth-1:0] n;
      case ($urandom_range(4))
         0: n = $urandom;
         1: n = $urandom_range(99999999);
         2: n = $urandom_range(999);
         3: n = POWER_OF_TEN[$urandom_range(9)] + $urandom_range(2) - 1;
         default: n = 32'hFFFF_FFFF - $urandom_range(1000);
      endcase
      return n;
   endfunction

   // compare every strobed digit with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_digits.size() == 0) begin
            report_mismatch("result with nothing pending, digit", 32'(rsp_digit_value), 0);
         end else begin
            scan_head = pending_digits.pop_front();
            digit_count++;
            if (rsp_digit_select !== scan_head.select)
               report_mismatch("digit_select", 32'(rsp_digit_select),
                               32'(scan_head.select));
            if (rsp_segment_pattern !== scan_head.segments)
               report_mismatch("segment_pattern", 32'(rsp_segment_pattern),
                               32'(scan_head.segments));
            if (rsp_digit_value !== scan_head.digit)
               report_mismatch("digit_value", 32'(rsp_digit_value),
                               32'(scan_head.digit));
            if (rsp_last_digit !== scan_head.last)
               report_mismatch("last_digit", 32'(rsp_last_digit),
                               32'(scan_head.last));
         end
      end
   end

   initial begin
      mismatch_count = 0;
      request_count  = 0;
      digit_count    = 0;
      idle_percent   = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_number_in  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table back to back
      foreach (directed_rows[i])
         send_request(directed_rows[i].number, directed_rows[i].has_bcd,
                      directed_rows[i].bcd);

      // random numbers: no gaps, then a busy sender gap, then a light one
      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 0 : (phase == 1) ? 51 : 22;
         repeat (ITEMS_PER_PHASE)
            send_request(pick_number(), 1'b0, '0);
      end

      // drop start and drain what the block still owes
      start <= 1'b0;
      while (pending_digits.size() != 0)
         @(posedge clock);
      repeat (2 * DIGITS + 4) @(posedge clock);

      if (pending_digits.size() != 0)
         report_mismatch("digits never sent, count", pending_digits.size(), 0);

      $display("Scanned %0d numbers into %0d digits: table rows, full-range,",
               request_count, digit_count);
      $display("eight-digit, small, power-of-ten and top-of-range values, with sender gaps.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // stop a hung run well past the slowest correct one
   initial begin
      #2000000;
      $display("timeout at %0t with %0d digits pending", $time, pending_digits.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
